/* design/ray_sphere_nearest_hit_assert.svh */
// ============================================================================
// ray sphere nearest hit assertion macros
// clocked property wrappers used by the top design file
// ============================================================================
`ifndef RAY_SPHERE_NEAREST_HIT_ASSERT_SVH
`define RAY_SPHERE_NEAREST_HIT_ASSERT_SVH

// same-cycle implication
`define RSNH_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSNH_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* design/rsnh_pkg.sv */
// ============================================================================
// rsnh_pkg
// shared widths, codes and sideband types of the ray sphere nearest hit block
// ============================================================================
`timescale 1ns / 1ps

package rsnh_pkg;

    localparam int MAX_SPHERES = 8;
    localparam int FRAC_BITS   = 16;

    localparam int POS_W  = 40;
    localparam int RAD_W  = 40;
    localparam int DIR_W  = 18;
    localparam int DIST_W = 40;
    localparam int EPS_W  = 16;
    localparam int CNT_W  = 4;
    localparam int EIDX_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int NUM_W = $clog2(MAX_SPHERES + 1);

    // center minus origin
    localparam int L_W   = POS_W + 1;
    localparam int LLO_W = L_W / 2;
    localparam int LHI_W = L_W - LLO_W;
    localparam int PLO_W = LLO_W + 1 + DIR_W;
    localparam int PHI_W = LHI_W + DIR_W;
    localparam int DOT_W = L_W + DIR_W + 2;

    // squares are split into two halves
    localparam int SLO_W = (L_W + 1) / 2;
    localparam int SHI_W = L_W - SLO_W;
    localparam int LSQ_W = 2 * L_W;
    localparam int LL_W  = LSQ_W + 2;

    localparam int RLO_W = (RAD_W + 1) / 2;
    localparam int RHI_W = RAD_W - RLO_W;
    localparam int R2_W  = 2 * RAD_W;

    localparam int B_W   = DOT_W - FRAC_BITS;
    localparam int BLO_W = (B_W + 1) / 2;
    localparam int BHI_W = B_W - BLO_W;
    localparam int B2_W  = 2 * B_W;

    localparam int MAX2_W  = (B2_W > R2_W) ? B2_W : R2_W;
    localparam int MAX3_W  = (MAX2_W > LL_W) ? MAX2_W : LL_W;
    localparam int DISC_W  = MAX3_W + 1;
    localparam int SQ_W    = (DISC_W + 1) / 2;
    localparam int TR_W    = 2 * SQ_W + 1;
    localparam int T_W     = ((B_W > SQ_W + 1) ? B_W : SQ_W + 1) + 1;

    localparam logic              REQ_LOAD = 1'b0;
    localparam logic              REQ_RAY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPHERES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_EPSILON    = 2'd1;

    localparam logic [EPS_W-1:0]  EPS_RESET = 16'd7;
    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

    typedef struct packed {
        logic             first;
        logic             last;
        logic             test;
        logic [IDX_W-1:0] k;
    } t_meta;

    typedef struct packed {
        t_meta                meta;
        logic                 miss;
        logic signed [B_W-1:0] b;
    } t_side;

endpackage

/* design/rsnh_geom.sv */
// ============================================================================
// rsnh_geom
// nine-stage pipeline from sphere and ray to b and the discriminant
// ============================================================================
`timescale 1ns / 1ps

module rsnh_geom (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_vld,
    input  rsnh_pkg::t_meta                      i_meta,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_org_x,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_org_y,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_org_z,
    input  logic signed [rsnh_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [rsnh_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [rsnh_pkg::DIR_W-1:0]    i_dir_z,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_cen_x,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_cen_y,
    input  logic signed [rsnh_pkg::POS_W-1:0]    i_cen_z,
    input  logic        [rsnh_pkg::RAD_W-1:0]    i_rad,
    output logic                                 o_vld,
    output rsnh_pkg::t_side                      o_side,
    output logic        [rsnh_pkg::DISC_W-1:0]   o_disc
);

    localparam int NST    = 9;
    localparam int L_W    = rsnh_pkg::L_W;
    localparam int LLO_W  = rsnh_pkg::LLO_W;
    localparam int SLO_W  = rsnh_pkg::SLO_W;
    localparam int RLO_W  = rsnh_pkg::RLO_W;
    localparam int BLO_W  = rsnh_pkg::BLO_W;
    localparam int DOT_W  = rsnh_pkg::DOT_W;
    localparam int LSQ_W  = rsnh_pkg::LSQ_W;
    localparam int LL_W   = rsnh_pkg::LL_W;
    localparam int R2_W   = rsnh_pkg::R2_W;
    localparam int B_W    = rsnh_pkg::B_W;
    localparam int B2_W   = rsnh_pkg::B2_W;
    localparam int DISC_W = rsnh_pkg::DISC_W;
    localparam int DIFF_W = DISC_W + 1;

    logic [NST-1:0]   r_vld;
    rsnh_pkg::t_meta  r_meta [NST];

    logic signed [rsnh_pkg::POS_W-1:0] w_cen [3];
    logic signed [rsnh_pkg::POS_W-1:0] w_org [3];
    logic signed [rsnh_pkg::DIR_W-1:0] w_dir [3];

    // stage 1
    logic signed [L_W-1:0]             r1_l [3];
    logic signed [rsnh_pkg::DIR_W-1:0] r1_d [3];
    logic        [rsnh_pkg::RAD_W-1:0] r1_rad;
    // stage 2
    logic        [L_W-1:0]                   r2_m [3];
    logic signed [rsnh_pkg::PLO_W-1:0]       r2_plo [3];
    logic signed [rsnh_pkg::PHI_W-1:0]       r2_phi [3];
    logic        [2*RLO_W-1:0]               r2_r00;
    logic        [RLO_W+rsnh_pkg::RHI_W-1:0] r2_r01;
    logic        [2*rsnh_pkg::RHI_W-1:0]     r2_r11;
    // stage 3
    logic signed [DOT_W-1:0]                 r3_p [3];
    logic        [2*SLO_W-1:0]               r3_s00 [3];
    logic        [SLO_W+rsnh_pkg::SHI_W-1:0] r3_s01 [3];
    logic        [2*rsnh_pkg::SHI_W-1:0]     r3_s11 [3];
    logic        [R2_W-1:0]                  r3_r2;
    // stage 4
    logic signed [DOT_W-1:0] r4_bf;
    logic        [LSQ_W-1:0] r4_sq [3];
    logic        [R2_W-1:0]  r4_r2;
    // stage 5
    logic signed [B_W-1:0]   w_b;
    logic signed [B_W-1:0]   r5_b;
    logic        [B_W-1:0]   r5_bm;
    logic        [LL_W-1:0]  r5_ll;
    logic        [R2_W-1:0]  r5_r2;
    // stage 6
    logic signed [B_W-1:0]                   r6_b;
    logic        [2*BLO_W-1:0]               r6_b00;
    logic        [BLO_W+rsnh_pkg::BHI_W-1:0] r6_b01;
    logic        [2*rsnh_pkg::BHI_W-1:0]     r6_b11;
    logic        [LL_W-1:0]                  r6_ll;
    logic        [R2_W-1:0]                  r6_r2;
    // stage 7
    logic signed [B_W-1:0]  r7_b;
    logic        [B2_W-1:0] r7_b2;
    logic        [LL_W-1:0] r7_ll;
    logic        [R2_W-1:0] r7_r2;
    // stage 8
    logic signed [B_W-1:0]    r8_b;
    logic        [DISC_W-1:0] r8_pos;
    logic        [LL_W-1:0]   r8_ll;
    // stage 9
    logic        [DIFF_W-1:0] w_diff;
    logic        [DISC_W-1:0] r9_disc;
    rsnh_pkg::t_side          r9_side;

    assign w_cen[0] = i_cen_x;
    assign w_cen[1] = i_cen_y;
    assign w_cen[2] = i_cen_z;
    assign w_org[0] = i_org_x;
    assign w_org[1] = i_org_y;
    assign w_org[2] = i_org_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    // floor of the dot product in output precision is the arithmetic shift
    assign w_b    = $signed(r4_bf[DOT_W-1:rsnh_pkg::FRAC_BITS]);
    assign w_diff = {1'b0, r8_pos} - DIFF_W'(r8_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meta[0] <= i_meta;
            for (int j = 1; j < NST; j++) begin
                r_meta[j] <= r_meta[j-1];
            end

            for (int c = 0; c < 3; c++) begin
                r1_l[c] <= L_W'(w_cen[c]) - L_W'(w_org[c]);
                r1_d[c] <= w_dir[c];
            end
            r1_rad <= i_rad;

            for (int c = 0; c < 3; c++) begin
                r2_m[c]   <= r1_l[c][L_W-1] ? (~r1_l[c] + 1'b1) : r1_l[c];
                r2_plo[c] <= $signed({1'b0, r1_l[c][LLO_W-1:0]}) * r1_d[c];
                r2_phi[c] <= $signed(r1_l[c][L_W-1:LLO_W]) * r1_d[c];
            end
            r2_r00 <= r1_rad[RLO_W-1:0] * r1_rad[RLO_W-1:0];
            r2_r01 <= r1_rad[RLO_W-1:0] * r1_rad[rsnh_pkg::RAD_W-1:RLO_W];
            r2_r11 <= r1_rad[rsnh_pkg::RAD_W-1:RLO_W] * r1_rad[rsnh_pkg::RAD_W-1:RLO_W];

            for (int c = 0; c < 3; c++) begin
                r3_p[c]   <= (DOT_W'(r2_phi[c]) <<< LLO_W) + DOT_W'(r2_plo[c]);
                r3_s00[c] <= r2_m[c][SLO_W-1:0] * r2_m[c][SLO_W-1:0];
                r3_s01[c] <= r2_m[c][SLO_W-1:0] * r2_m[c][L_W-1:SLO_W];
                r3_s11[c] <= r2_m[c][L_W-1:SLO_W] * r2_m[c][L_W-1:SLO_W];
            end
            r3_r2 <= (R2_W'(r2_r11) << (2 * RLO_W)) + (R2_W'(r2_r01) << (RLO_W + 1))
                     + R2_W'(r2_r00);

            r4_bf <= r3_p[0] + r3_p[1] + r3_p[2];
            for (int c = 0; c < 3; c++) begin
                r4_sq[c] <= (LSQ_W'(r3_s11[c]) << (2 * SLO_W))
                            + (LSQ_W'(r3_s01[c]) << (SLO_W + 1)) + LSQ_W'(r3_s00[c]);
            end
            r4_r2 <= r3_r2;

            r5_b  <= w_b;
            r5_bm <= w_b[B_W-1] ? (~w_b + 1'b1) : w_b;
            r5_ll <= LL_W'(r4_sq[0]) + LL_W'(r4_sq[1]) + LL_W'(r4_sq[2]);
            r5_r2 <= r4_r2;

            r6_b   <= r5_b;
            r6_b00 <= r5_bm[BLO_W-1:0] * r5_bm[BLO_W-1:0];
            r6_b01 <= r5_bm[BLO_W-1:0] * r5_bm[B_W-1:BLO_W];
            r6_b11 <= r5_bm[B_W-1:BLO_W] * r5_bm[B_W-1:BLO_W];
            r6_ll  <= r5_ll;
            r6_r2  <= r5_r2;

            r7_b  <= r6_b;
            r7_b2 <= (B2_W'(r6_b11) << (2 * BLO_W)) + (B2_W'(r6_b01) << (BLO_W + 1))
                     + B2_W'(r6_b00);
            r7_ll <= r6_ll;
            r7_r2 <= r6_r2;

            r8_b   <= r7_b;
            r8_pos <= DISC_W'(r7_b2) + DISC_W'(r7_r2);
            r8_ll  <= r7_ll;

            // a borrow out of the subtract means a negative discriminant
            r9_disc      <= w_diff[DISC_W-1:0];
            r9_side.miss <= w_diff[DISC_W];
            r9_side.b    <= r8_b;
            r9_side.meta <= r_meta[NST-2];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_side = r9_side;
    assign o_disc = r9_disc;

endmodule

/* design/rsnh_sqrt.sv */
// ============================================================================
// rsnh_sqrt
// pipelined integer square root, one result bit per stage
// ============================================================================
`timescale 1ns / 1ps

module rsnh_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_vld,
    input  rsnh_pkg::t_side                    i_side,
    input  logic [rsnh_pkg::DISC_W-1:0]        i_disc,
    output logic                               o_vld,
    output rsnh_pkg::t_side                    o_side,
    output logic [rsnh_pkg::SQ_W-1:0]          o_root
);

    localparam int SQ_W   = rsnh_pkg::SQ_W;
    localparam int DISC_W = rsnh_pkg::DISC_W;
    localparam int TR_W   = rsnh_pkg::TR_W;

    logic [SQ_W-1:0]   r_vld;
    logic [DISC_W-1:0] r_rem   [SQ_W];
    logic [SQ_W-1:0]   r_root  [SQ_W];
    rsnh_pkg::t_side   r_side  [SQ_W];
    logic [DISC_W-1:0] n_rem   [SQ_W];
    logic [SQ_W-1:0]   n_root  [SQ_W];
    logic [DISC_W-1:0] w_rin   [SQ_W];
    logic [SQ_W-1:0]   w_qin   [SQ_W];
    logic [TR_W-1:0]   w_trial [SQ_W];
    logic [SQ_W-1:0]   w_ge;

    // remainder holds value minus root squared; try the next bit against it
    always_comb begin
        w_rin[0] = i_disc;
        w_qin[0] = '0;
        for (int j = 1; j < SQ_W; j++) begin
            w_rin[j] = r_rem[j-1];
            w_qin[j] = r_root[j-1];
        end
        for (int j = 0; j < SQ_W; j++) begin
            w_trial[j] = (TR_W'(w_qin[j]) << (SQ_W - j))
                         | (TR_W'(1) << (2 * (SQ_W - 1 - j)));
            w_ge[j]    = TR_W'(w_rin[j]) >= w_trial[j];
            n_rem[j]   = w_ge[j] ? DISC_W'(TR_W'(w_rin[j]) - w_trial[j]) : w_rin[j];
            n_root[j]  = w_qin[j] | (SQ_W'(w_ge[j]) << (SQ_W - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[SQ_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int j = 1; j < SQ_W; j++) begin
                r_side[j] <= r_side[j-1];
            end
            for (int j = 0; j < SQ_W; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_vld  = r_vld[SQ_W-1];
    assign o_side = r_side[SQ_W-1];
    assign o_root = r_root[SQ_W-1];

endmodule

/* design/ray_sphere_nearest_hit.sv */
// ============================================================================
// ray_sphere_nearest_hit
// sphere table with a pipelined ray/sphere test and nearest hit reduction
// ============================================================================
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   req_type entry_index radius pos dir
//  out       output     o_out_valid / i_out_ready hit distance sphere_index
//  cfg       input      i_cfg_valid / o_cfg_ready cfg_index cfg_data
//
//  a sphere load is written on acceptance; a ray issues max(n, 1) entries, n
//  being spheres_in_use capped at the table size, as the issue sequencer feeds
//  one table entry per cycle into the test pipeline unless a held result stalls
//  it. the next transaction is taken on the last issue cycle. the result follows
//  the last entry through geometry (9 stages), square root (46) and select (3).
//  reset clears control only; table entries are undefined until loaded.
//  a held result stalls the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module ray_sphere_nearest_hit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic        [rsnh_pkg::EIDX_W-1:0]    i_entry_index,
    input  logic        [rsnh_pkg::RAD_W-1:0]     i_radius,
    input  logic signed [rsnh_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [rsnh_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [rsnh_pkg::POS_W-1:0]     i_pos_z,
    input  logic signed [rsnh_pkg::DIR_W-1:0]     i_dir_x,
    input  logic signed [rsnh_pkg::DIR_W-1:0]     i_dir_y,
    input  logic signed [rsnh_pkg::DIR_W-1:0]     i_dir_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_hit,
    output logic        [rsnh_pkg::DIST_W-1:0]    o_distance,
    output logic        [rsnh_pkg::EIDX_W-1:0]    o_sphere_index,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [rsnh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [rsnh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    `include "ray_sphere_nearest_hit_assert.svh"

    localparam int IDX_W  = rsnh_pkg::IDX_W;
    localparam int NUM_W  = rsnh_pkg::NUM_W;
    localparam int POS_W  = rsnh_pkg::POS_W;
    localparam int DIR_W  = rsnh_pkg::DIR_W;
    localparam int RAD_W  = rsnh_pkg::RAD_W;
    localparam int DIST_W = rsnh_pkg::DIST_W;
    localparam int T_W    = rsnh_pkg::T_W;

    // configuration
    logic [rsnh_pkg::CNT_W-1:0] r_count;
    logic [rsnh_pkg::EPS_W-1:0] r_eps;
    logic [NUM_W-1:0]           w_n_eff;

    // sequencer
    logic                r_busy;
    logic [IDX_W-1:0]    r_k;
    logic [NUM_W-1:0]    r_n;
    logic [NUM_W:0]      w_k_next;
    logic                w_iss_last;
    logic                w_issue;
    logic                w_adv;
    logic                w_in_acc;
    logic                w_ray_acc;
    logic                w_load_acc;
    logic [IDX_W-1:0]    w_wr_idx;
    logic signed [POS_W-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_dir_z;

    // sphere table
    logic signed [POS_W-1:0] r_mem_cx [rsnh_pkg::MAX_SPHERES];
    logic signed [POS_W-1:0] r_mem_cy [rsnh_pkg::MAX_SPHERES];
    logic signed [POS_W-1:0] r_mem_cz [rsnh_pkg::MAX_SPHERES];
    logic        [RAD_W-1:0] r_mem_r  [rsnh_pkg::MAX_SPHERES];

    // issue stage
    logic                    r_iss_vld;
    rsnh_pkg::t_meta         r_iss_meta;
    logic signed [POS_W-1:0] r_iss_ox, r_iss_oy, r_iss_oz;
    logic signed [DIR_W-1:0] r_iss_dx, r_iss_dy, r_iss_dz;
    logic signed [POS_W-1:0] r_rd_cx, r_rd_cy, r_rd_cz;
    logic        [RAD_W-1:0] r_rd_r;

    // between units
    logic                             g_vld;
    rsnh_pkg::t_side                  g_side;
    logic [rsnh_pkg::DISC_W-1:0]      g_disc;
    logic                             s_vld;
    rsnh_pkg::t_side                  s_side;
    logic [rsnh_pkg::SQ_W-1:0]        s_root;

    // select stages
    logic signed [T_W-1:0]   w_b;
    logic signed [T_W-1:0]   w_s;
    logic                    r_f1_vld;
    rsnh_pkg::t_side         r_f1_side;
    logic signed [T_W-1:0]   r_f1_lo;
    logic signed [T_W-1:0]   r_f1_hi;
    logic signed [T_W-1:0]   w_eps;
    logic signed [T_W-1:0]   w_dmax;
    logic                    w_c_lo;
    logic                    w_c_hi;
    logic                    r_f2_vld;
    rsnh_pkg::t_meta         r_f2_meta;
    logic                    r_f2_hit;
    logic [DIST_W-1:0]       r_f2_dist;

    // reduction and output
    logic                r_acc_found;
    logic [DIST_W-1:0]   r_acc_dist;
    logic [IDX_W-1:0]    r_acc_k;
    logic                w_base_found;
    logic                w_take;
    logic                n_found;
    logic [DIST_W-1:0]   n_dist;
    logic [IDX_W-1:0]    n_k;
    logic                r_out_valid;
    logic                r_out_hit;
    logic [DIST_W-1:0]   r_out_dist;
    logic [rsnh_pkg::EIDX_W-1:0] r_out_idx;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_eps   <= rsnh_pkg::EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsnh_pkg::REG_SPHERES_IN_USE: r_count <= i_cfg_data[rsnh_pkg::CNT_W-1:0];
                rsnh_pkg::REG_HIT_EPSILON:    r_eps   <= i_cfg_data[rsnh_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_n_eff = (32'(r_count) > rsnh_pkg::MAX_SPHERES)
                     ? NUM_W'(rsnh_pkg::MAX_SPHERES) : NUM_W'(r_count);

    // ------------------------------------------------------------------
    // input side and issue sequencer
    // ------------------------------------------------------------------
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_issue    = r_busy && w_adv;
    assign w_k_next   = (NUM_W + 1)'(r_k) + 1'b1;
    assign w_iss_last = w_k_next >= (NUM_W + 1)'(r_n);
    assign o_in_ready = !r_busy || (w_issue && w_iss_last);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_ray_acc  = w_in_acc && (i_req_type == rsnh_pkg::REQ_RAY);
    assign w_load_acc = w_in_acc && (i_req_type == rsnh_pkg::REQ_LOAD)
                        && (32'(i_entry_index) < rsnh_pkg::MAX_SPHERES);
    assign w_wr_idx   = IDX_W'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (w_ray_acc) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (w_issue) begin
            if (w_iss_last) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ray_acc) begin
            r_org_x <= i_pos_x;
            r_org_y <= i_pos_y;
            r_org_z <= i_pos_z;
            r_dir_x <= i_dir_x;
            r_dir_y <= i_dir_y;
            r_dir_z <= i_dir_z;
            r_n     <= w_n_eff;
        end
    end

    // table write on load, registered read on issue
    always_ff @(posedge i_clk) begin
        if (w_load_acc) begin
            r_mem_cx[w_wr_idx] <= i_pos_x;
            r_mem_cy[w_wr_idx] <= i_pos_y;
            r_mem_cz[w_wr_idx] <= i_pos_z;
            r_mem_r[w_wr_idx]  <= i_radius;
        end
        if (w_issue) begin
            r_rd_cx <= r_mem_cx[r_k];
            r_rd_cy <= r_mem_cy[r_k];
            r_rd_cz <= r_mem_cz[r_k];
            r_rd_r  <= r_mem_r[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_vld <= 1'b0;
        end else if (w_adv) begin
            r_iss_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_iss_meta.first <= (r_k == '0);
            r_iss_meta.last  <= w_iss_last;
            r_iss_meta.test  <= (r_n != '0);
            r_iss_meta.k     <= r_k;
            r_iss_ox <= r_org_x;
            r_iss_oy <= r_org_y;
            r_iss_oz <= r_org_z;
            r_iss_dx <= r_dir_x;
            r_iss_dy <= r_dir_y;
            r_iss_dz <= r_dir_z;
        end
    end

    // ------------------------------------------------------------------
    // test pipeline
    // ------------------------------------------------------------------
    rsnh_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_iss_vld),
        .i_meta  (r_iss_meta),
        .i_org_x (r_iss_ox),
        .i_org_y (r_iss_oy),
        .i_org_z (r_iss_oz),
        .i_dir_x (r_iss_dx),
        .i_dir_y (r_iss_dy),
        .i_dir_z (r_iss_dz),
        .i_cen_x (r_rd_cx),
        .i_cen_y (r_rd_cy),
        .i_cen_z (r_rd_cz),
        .i_rad   (r_rd_r),
        .o_vld   (g_vld),
        .o_side  (g_side),
        .o_disc  (g_disc)
    );

    rsnh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (g_vld),
        .i_side  (g_side),
        .i_disc  (g_disc),
        .o_vld   (s_vld),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    // near and far roots
    assign w_b = T_W'($signed(s_side.b));
    assign w_s = $signed(T_W'(s_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld <= s_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    assign w_eps  = $signed(T_W'(r_eps));
    assign w_dmax = $signed(T_W'(rsnh_pkg::DIST_MAX));
    assign w_c_lo = r_f1_lo > w_eps;
    assign w_c_hi = r_f1_hi > w_eps;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_side <= s_side;
            r_f1_lo   <= w_b - w_s;
            r_f1_hi   <= w_b + w_s;

            r_f2_meta <= r_f1_side.meta;
            r_f2_hit  <= r_f1_side.meta.test && !r_f1_side.miss && (w_c_lo || w_c_hi);
            if (w_c_lo) begin
                r_f2_dist <= (r_f1_lo > w_dmax) ? rsnh_pkg::DIST_MAX : DIST_W'(r_f1_lo);
            end else begin
                r_f2_dist <= (r_f1_hi > w_dmax) ? rsnh_pkg::DIST_MAX : DIST_W'(r_f1_hi);
            end
        end
    end

    // ------------------------------------------------------------------
    // nearest hit over the ray's entries, lowest index wins ties
    // ------------------------------------------------------------------
    assign w_base_found = !r_f2_meta.first && r_acc_found;
    assign w_take       = r_f2_hit && (!w_base_found || (r_f2_dist < r_acc_dist));
    assign n_found      = w_base_found || r_f2_hit;
    assign n_dist       = w_take ? r_f2_dist : r_acc_dist;
    assign n_k          = w_take ? r_f2_meta.k : r_acc_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_f2_vld && r_f2_meta.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_f2_vld) begin
            if (r_f2_meta.last) begin
                r_out_hit  <= n_found;
                r_out_dist <= n_found ? n_dist : '0;
                r_out_idx  <= n_found ? rsnh_pkg::EIDX_W'(n_k) : '0;
            end else begin
                r_acc_found <= n_found;
                r_acc_dist  <= n_dist;
                r_acc_k     <= n_k;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_distance     = r_out_dist;
    assign o_sphere_index = r_out_idx;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RSNH_ASSERT_NOW(a_miss_zero, o_out_valid && !o_hit,
        (o_distance == '0) && (o_sphere_index == '0), "miss result carries nonzero fields")
    `RSNH_ASSERT_NOW(a_hit_past_eps, o_out_valid && o_hit,
        o_distance > DIST_W'(r_eps), "hit distance not beyond epsilon")
    `RSNH_ASSERT_NOW(a_hit_in_range, o_out_valid && o_hit,
        o_sphere_index < w_n_eff, "hit index outside tested entries")
    `RSNH_ASSERT_NEXT(a_seq_done, w_issue && w_iss_last && !w_ray_acc,
        !r_busy, "sequencer still busy after last entry")
    `RSNH_ASSERT_NOW(a_no_take_busy, r_busy && !(w_issue && w_iss_last),
        !o_in_ready, "transaction taken while entries remain to issue")

endmodule

/* verif/tb_ray_sphere_nearest_hit.sv */
// ============================================================================
// tb_ray_sphere_nearest_hit
// loads the sphere table, casts rays under several count and epsilon
// settings with random valid/ready gaps, and checks every result against a
// fixed-point nearest hit predictor kept in step with each transaction
// ============================================================================
`timescale 1ns / 1ps

module tb_ray_sphere_nearest_hit;

    localparam int MAX_SPHERES = rsnh_pkg::MAX_SPHERES;
    localparam int FRAC_BITS   = rsnh_pkg::FRAC_BITS;
    localparam int EIDX_W      = rsnh_pkg::EIDX_W;
    localparam int RAD_W       = rsnh_pkg::RAD_W;
    localparam int POS_W       = rsnh_pkg::POS_W;
    localparam int DIR_W       = rsnh_pkg::DIR_W;
    localparam int DIST_W      = rsnh_pkg::DIST_W;
    localparam int CNT_W       = rsnh_pkg::CNT_W;
    localparam int EPS_W       = rsnh_pkg::EPS_W;
    localparam int CFG_IDX_W   = rsnh_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = rsnh_pkg::CFG_DATA_W;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic                    req_type;
        logic [EIDX_W-1:0]       entry_index;
        logic [RAD_W-1:0]        radius;
        logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
        logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
    } t_req;

    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [EIDX_W-1:0] sphere_index;
    } t_hit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam longint ONE        = 65536;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, i_req_type;
    logic [EIDX_W-1:0] i_entry_index;
    logic [RAD_W-1:0] i_radius;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [DIR_W-1:0] i_dir_x, i_dir_y, i_dir_z;
    logic o_out_valid, i_out_ready, o_hit;
    logic [DIST_W-1:0] o_distance;
    logic [EIDX_W-1:0] o_sphere_index;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ray_sphere_nearest_hit DUT (.*);

    // predictor state
    logic [POS_W-1:0] ctr_x [MAX_SPHERES];
    logic [POS_W-1:0] ctr_y [MAX_SPHERES];
    logic [POS_W-1:0] ctr_z [MAX_SPHERES];
    logic [RAD_W-1:0] rad [MAX_SPHERES];
    logic [CNT_W-1:0] count_cfg = '0;
    logic [EPS_W-1:0] eps_cfg = rsnh_pkg::EPS_RESET;

    t_req pending_reqs[$];
    t_hit expected_hits[$];
    int   snd_idle_pct = 0, rcv_idle_pct = 0;
    bit   failed = 0;
    logic hold_go = 0;
    bit   hold_taken = 0;
    int   hold_cnt = 0;
    int   quiet_cycles = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0] r, c;
        r = 0;
        for (int bit_n = 63; bit_n >= 0; bit_n--) begin
            c = r | (64'd1 << bit_n);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_hit nearest_hit_of(t_req q);
        t_hit res;
        longint o[3], d[3], c[3], l, bf, b, s, t, eps, best, cand;
        longint unsigned lab, bm;
        logic [127:0] ll, pos, disc;
        int n;
        res = '{1'b0, '0, '0};
        best = 0;
        o = '{longint'(q.pos_x), longint'(q.pos_y), longint'(q.pos_z)};
        d = '{longint'(q.dir_x), longint'(q.dir_y), longint'(q.dir_z)};
        eps = longint'(eps_cfg);
        n = (int'(count_cfg) > MAX_SPHERES) ? MAX_SPHERES : int'(count_cfg);
        for (int k = 0; k < n; k++) begin
            c = '{longint'($signed(ctr_x[k])), longint'($signed(ctr_y[k])),
                  longint'($signed(ctr_z[k]))};
            bf = 0;
            ll = 0;
            for (int a = 0; a < 3; a++) begin
                l = c[a] - o[a];
                bf += l * d[a];
                lab = (l < 0) ? -l : l;
                ll += {64'd0, lab} * {64'd0, lab};
            end
            b = bf >>> FRAC_BITS;   // floor
            bm = (b < 0) ? -b : b;
            pos = {64'd0, bm} * {64'd0, bm} + {88'd0, rad[k]} * {88'd0, rad[k]};
            if (pos < ll) continue;
            disc = pos - ll;
            s = longint'(isqrt128(disc));
            if (b - s > eps) t = b - s;
            else if (b + s > eps) t = b + s;
            else continue;
            cand = (t > longint'(rsnh_pkg::DIST_MAX)) ? longint'(rsnh_pkg::DIST_MAX) : t;
            if (!res.hit || cand < best) begin
                res.hit = 1;
                best = cand;
                res.sphere_index = EIDX_W'(k);
            end
        end
        res.distance = DIST_W'(best);
        return res;
    endfunction

    // driver: input channel, prediction at acceptance
    always @(posedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_req_type == rsnh_pkg::REQ_LOAD) begin
                    ctr_x[i_entry_index] = i_pos_x;
                    ctr_y[i_entry_index] = i_pos_y;
                    ctr_z[i_entry_index] = i_pos_z;
                    rad[i_entry_index]   = i_radius;
                end else begin
                    q = '{i_req_type, i_entry_index, i_radius, i_pos_x, i_pos_y,
                          i_pos_z, i_dir_x, i_dir_y, i_dir_z};
                    expected_hits.push_back(nearest_hit_of(q));
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    q = pending_reqs.pop_front();
                    i_in_valid    <= 1;
                    i_req_type    <= q.req_type;
                    i_entry_index <= q.entry_index;
                    i_radius      <= q.radius;
                    i_pos_x <= q.pos_x;
                    i_pos_y <= q.pos_y;
                    i_pos_z <= q.pos_z;
                    i_dir_x <= q.dir_x;
                    i_dir_y <= q.dir_y;
                    i_dir_z <= q.dir_z;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_hit e;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("result transaction with nothing expected");
                    failed = 1;
                end else begin
                    e = expected_hits.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit: expected %0d actual %0d", e.hit, o_hit);
                        failed = 1;
                    end
                    if (o_distance !== e.distance) begin
                        $error("distance: expected %0d actual %0d", e.distance, o_distance);
                        failed = 1;
                    end
                    if (o_sphere_index !== e.sphere_index) begin
                        $error("sphere_index: expected %0d actual %0d",
                               e.sphere_index, o_sphere_index);
                        failed = 1;
                    end
                end
            end
            if (hold_go && !hold_taken) begin
                hold_taken <= 1;
                hold_cnt   <= HOLD_CYCLES;
                i_out_ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ray_sphere_nearest_hit");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rsnh_pkg::REG_SPHERES_IN_USE) count_cfg = data[CNT_W-1:0];
        else if (idx == rsnh_pkg::REG_HIT_EPSILON) eps_cfg = data[EPS_W-1:0];
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid || expected_hits.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rnd40();
        return 40'({$urandom, $urandom});
    endfunction

    function automatic longint scene_coord(int span_units);
        return longint'($urandom_range(0, 2 * span_units * ONE)) - span_units * ONE;
    endfunction

    function automatic t_req noise_req();
        t_req q;
        q.req_type = 1'($urandom_range(0, 1));
        q.entry_index = EIDX_W'($urandom);
        q.radius = rnd40();
        q.pos_x = rnd40();
        q.pos_y = rnd40();
        q.pos_z = rnd40();
        q.dir_x = DIR_W'($urandom);
        q.dir_y = DIR_W'($urandom);
        q.dir_z = DIR_W'($urandom);
        return q;
    endfunction

    function automatic t_req scene_load(int slot);
        t_req q;
        q = noise_req();
        q.req_type = rsnh_pkg::REQ_LOAD;
        q.entry_index = EIDX_W'(slot);
        q.radius = RAD_W'(longint'($urandom_range(ONE, 12 * ONE)));
        q.pos_x = POS_W'(scene_coord(30));
        q.pos_y = POS_W'(scene_coord(30));
        q.pos_z = POS_W'(scene_coord(30));
        return q;
    endfunction

    function automatic t_req scene_ray();
        t_req q;
        q = noise_req();
        q.req_type = rsnh_pkg::REQ_RAY;
        q.pos_x = POS_W'(scene_coord(40));
        q.pos_y = POS_W'(scene_coord(40));
        q.pos_z = POS_W'(scene_coord(40));
        q.dir_x = DIR_W'(longint'($urandom_range(0, 2 * ONE)) - ONE);
        q.dir_y = DIR_W'(longint'($urandom_range(0, 2 * ONE)) - ONE);
        q.dir_z = DIR_W'(longint'($urandom_range(0, 2 * ONE)) - ONE);
        return q;
    endfunction

    function automatic t_req make_ray(longint ox, longint oy, longint oz,
                                      int dx, int dy, int dz);
        t_req q;
        q = noise_req();
        q.req_type = rsnh_pkg::REQ_RAY;
        q.pos_x = POS_W'(ox);
        q.pos_y = POS_W'(oy);
        q.pos_z = POS_W'(oz);
        q.dir_x = DIR_W'(dx);
        q.dir_y = DIR_W'(dy);
        q.dir_z = DIR_W'(dz);
        return q;
    endfunction

    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) pending_reqs.push_back(noise_req());
            else if (r < 25) pending_reqs.push_back(scene_load($urandom_range(0, 7)));
            else pending_reqs.push_back(scene_ray());
        end
    endtask

    initial begin
        t_req q;
        t_req tie_req;
        i_rst_n = 0;
        i_in_valid = 0;
        i_req_type = 0;
        i_entry_index = 0;
        i_radius = 0;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        i_dir_x = 0;
        i_dir_y = 0;
        i_dir_z = 0;
        i_out_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // count zero at reset: rays miss, table not yet loaded
        snd_idle_pct = 18;
        rcv_idle_pct = 61;
        pending_reqs.push_back(make_ray(0, 0, 0, 65536, 0, 0));
        pending_reqs.push_back(noise_req());
        pending_reqs[$].req_type = rsnh_pkg::REQ_RAY;
        for (int k = 0; k < MAX_SPHERES; k++) pending_reqs.push_back(scene_load(k));
        // slot 3 duplicates slot 2 for a tie
        q = pending_reqs[$ - 5];
        q.entry_index = 3;
        tie_req = q;
        pending_reqs.push_back(q);
        // extreme sphere at the far positive end of the x axis
        q = scene_load(7);
        q.radius = rsnh_pkg::DIST_MAX;
        q.pos_x = {1'b0, {39{1'b1}}};
        q.pos_y = '0;
        q.pos_z = '0;
        pending_reqs.push_back(q);
        // a zero radius sphere right in front of the origin
        q = scene_load(6);
        q.radius = '0;
        q.pos_x = POS_W'(5 * ONE);
        q.pos_y = '0;
        q.pos_z = '0;
        pending_reqs.push_back(q);
        drain();

        write_reg(rsnh_pkg::REG_SPHERES_IN_USE, 16'd8);
        write_reg(rsnh_pkg::REG_HIT_EPSILON, rsnh_pkg::EPS_RESET);
        // far hit saturates the distance
        pending_reqs.push_back(make_ray(-(longint'(1) << 39), 0, 0, 131071, 0, 0));
        pending_reqs.push_back(make_ray(-(longint'(1) << 39), 0, 0, -131072, -131072, -131072));
        pending_reqs.push_back(make_ray(longint'({1'b0, {39{1'b1}}}), 0, 0, 65536, 0, 0));
        pending_reqs.push_back(make_ray(0, 0, 0, 65536, 0, 0));
        pending_reqs.push_back(make_ray(0, 0, 0, -65536, 0, 0));
        pending_reqs.push_back(make_ray(0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_ray(0, 0, 0, 131071, 131071, 131071));
        // aimed at the duplicated pair, from outside then from inside one
        pending_reqs.push_back(make_ray(longint'(tie_req.pos_x) - 20 * ONE,
                                        longint'(tie_req.pos_y), longint'(tie_req.pos_z),
                                        65536, 0, 0));
        pending_reqs.push_back(make_ray(longint'(tie_req.pos_x), longint'(tie_req.pos_y),
                                        longint'(tie_req.pos_z), 65536, 0, 0));
        for (int i = 0; i < 4; i++) begin
            pending_reqs.push_back(scene_ray());
        end
        queue_random(150);
        drain();

        write_reg(rsnh_pkg::REG_SPHERES_IN_USE, 16'd15);
        write_reg(rsnh_pkg::REG_HIT_EPSILON, 16'd0);
        queue_random(150);
        @(posedge i_clk);
        hold_go <= 1;
        drain();

        snd_idle_pct = 61;
        rcv_idle_pct = 18;
        write_reg(rsnh_pkg::REG_SPHERES_IN_USE, 16'd3);
        write_reg(rsnh_pkg::REG_HIT_EPSILON, 16'hFFFF);
        queue_random(150);
        drain();

        write_reg(rsnh_pkg::REG_SPHERES_IN_USE, 16'd1);
        write_reg(rsnh_pkg::REG_HIT_EPSILON, 16'd1000);
        queue_random(150);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // unknown register indexes change nothing
        write_reg(REG_SPARE_A, 16'h0);
        write_reg(REG_SPARE_B, 16'h0003);
        write_reg(rsnh_pkg::REG_SPHERES_IN_USE, 16'd8);
        write_reg(rsnh_pkg::REG_HIT_EPSILON, rsnh_pkg::EPS_RESET);
        queue_random(275);
        drain();

        if (!failed && expected_hits.size() == 0) begin
            $display("PASS ray_sphere_nearest_hit");
        end else begin
            $display("FAIL ray_sphere_nearest_hit");
        end
        $finish;
    end

endmodule

/* ray_sphere_nearest_hit.f */
+incdir+design
design/rsnh_pkg.sv
design/rsnh_geom.sv
design/rsnh_sqrt.sv
design/ray_sphere_nearest_hit.sv
verif/tb_ray_sphere_nearest_hit.sv
